### sv/sdbc_pkg.sv
// Shared types, codes and constants of the sensor-driven blind controller.
package sdbc_pkg;

   // Input beat actions
   localparam logic [2:0] ACT_TEMP_SAMPLE  = 3'd0;
   localparam logic [2:0] ACT_LIGHT_SAMPLE = 3'd1;
   localparam logic [2:0] ACT_TEMP_AVG     = 3'd2;
   localparam logic [2:0] ACT_LIGHT_AVG    = 3'd3;
   localparam logic [2:0] ACT_MOVE_TICK    = 3'd4;
   localparam logic [2:0] ACT_OPEN         = 3'd5;
   localparam logic [2:0] ACT_CLOSE        = 3'd6;

   // Blind modes
   localparam logic [1:0] MODE_UP       = 2'd0;
   localparam logic [1:0] MODE_LOWERING = 2'd1;
   localparam logic [1:0] MODE_DOWN     = 2'd2;
   localparam logic [1:0] MODE_RAISING  = 2'd3;

   // Report kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_LIGHT  = 2'd1;
   localparam logic [1:0] KIND_TEMP   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   // Status report values
   localparam logic [7:0] STATUS_CLOSED = 8'd0;
   localparam logic [7:0] STATUS_MOVING = 8'd1;
   localparam logic [7:0] STATUS_OPEN   = 8'd2;

   // Config register indexes
   localparam logic [2:0] CSR_CLOSE_TEMP = 3'd0;
   localparam logic [2:0] CSR_OPEN_TEMP  = 3'd1;
   localparam logic [2:0] CSR_CLOSE_LIGHT = 3'd2;
   localparam logic [2:0] CSR_OPEN_LIGHT = 3'd3;
   localparam logic [2:0] CSR_OPEN_POS   = 3'd4;
   localparam logic [2:0] CSR_CLOSED_POS = 3'd5;
   localparam logic [2:0] CSR_MOVE_STEP  = 3'd6;

   // Config reset values
   localparam logic [7:0] RST_CLOSE_TEMP  = 8'd25;
   localparam logic [7:0] RST_OPEN_TEMP   = 8'd20;
   localparam logic [7:0] RST_CLOSE_LIGHT = 8'd95;
   localparam logic [7:0] RST_OPEN_LIGHT  = 8'd30;
   localparam logic [7:0] RST_OPEN_POS    = 8'd10;
   localparam logic [7:0] RST_CLOSED_POS  = 8'd110;
   localparam logic [7:0] RST_MOVE_STEP   = 8'd10;

   // Averaging: sum / AVERAGE_COUNT as multiply by rounded-up reciprocal, exact for 16-bit sums
   localparam int SUM_W         = 16;
   localparam int AVERAGE_COUNT = 5;
   localparam int AVG_SHIFT     = SUM_W + $clog2(AVERAGE_COUNT);
   localparam int AVG_RECIP     = ((1 << AVG_SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT;
   localparam int AVG_PROD_W    = SUM_W + 18;

   // Sample conversion constants
   localparam int TEMP_SCALE  = 500;
   localparam int TEMP_OFFSET = 51200;
   localparam int LIGHT_MUL   = 25700;   // 100 * 257, divide by 255 via 257/65536
   localparam int LIGHT_BIAS  = 257;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [2:0] action;
      logic [9:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] report_kind;
      logic [7:0] report_value;
      logic [1:0] blind_mode;
      logic [8:0] position;
      logic       red_lamp;
      logic       green_lamp;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      logic            two;
      rsp_payload_type first;
      rsp_payload_type second;
   } sdbc_push_type;

endpackage

### sv/sdbc_core.sv
// Blind controller state, config registers and per-beat result generation.
module sdbc_core
   import sdbc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [2:0]      csr_index,
   input  logic [7:0]      csr_data,
   input  logic            item_go,
   input  req_payload_type item,
   output sdbc_push_type   push
);

   logic [7:0]       close_temp_ff, open_temp_ff, close_light_ff, open_light_ff;
   logic [7:0]       open_pos_ff, closed_pos_ff, move_step_ff;
   logic [1:0]       mode_ff, mode_in;
   logic [8:0]       pos_ff, pos_in;
   logic [SUM_W-1:0] tsum_ff, tsum_in, lsum_ff, lsum_in;

   logic [18:0]           temp_prod, temp_diff;
   logic [7:0]            temp_val;
   logic [7:0]            light_m;
   logic [22:0]           light_prod;
   logic [6:0]            light_val;
   logic [SUM_W:0]        tsum_add, lsum_add;
   logic [SUM_W-1:0]      avg_src, avg;
   logic [AVG_PROD_W-1:0] avg_prod;
   logic [7:0]            thr_close, thr_open;
   logic [SUM_W:0]        temp_rep;
   logic [9:0]            lower_sum;
   logic [8:0]            lower_pos, raise_pos;
   logic                  status_hit, meas_hit;
   logic [7:0]            status_val, meas_val;
   logic [1:0]            meas_kind;
   rsp_payload_type       res_a, res_b;

   // Sample conversion
   always_comb begin
      temp_prod = 19'(item.sample) * 19'(TEMP_SCALE);
      temp_diff = temp_prod - 19'(TEMP_OFFSET);
      if (temp_prod < 19'(TEMP_OFFSET)) begin
         temp_val = 8'd0;
      end else if (temp_diff[18:10] > 9'd255) begin
         temp_val = 8'd255;
      end else begin
         temp_val = temp_diff[17:10];
      end
      light_m    = 8'd255 - item.sample[9:2];
      light_prod = 23'(light_m) * 23'(LIGHT_MUL) + 23'(LIGHT_BIAS);
      light_val  = light_prod[22:16];
      tsum_add   = {1'b0, tsum_ff} + (SUM_W+1)'(temp_val);
      lsum_add   = {1'b0, lsum_ff} + (SUM_W+1)'(light_val);
   end

   // Average of the selected sum, its thresholds and the next move positions
   always_comb begin
      avg_src   = (item.action == ACT_LIGHT_AVG) ? lsum_ff : tsum_ff;
      thr_close = (item.action == ACT_LIGHT_AVG) ? close_light_ff : close_temp_ff;
      thr_open  = (item.action == ACT_LIGHT_AVG) ? open_light_ff : open_temp_ff;
      avg_prod  = AVG_PROD_W'(avg_src) * AVG_PROD_W'(AVG_RECIP);
      avg       = SUM_W'(avg_prod >> AVG_SHIFT);
      temp_rep  = (SUM_W+1)'(avg) + (SUM_W+1)'(128);
      lower_sum = 10'(pos_ff) + 10'(move_step_ff);
      lower_pos = lower_sum[9] ? 9'd511 : lower_sum[8:0];
      raise_pos = (pos_ff > 9'(move_step_ff)) ? pos_ff - 9'(move_step_ff) : 9'd0;
   end

   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      tsum_in    = tsum_ff;
      lsum_in    = lsum_ff;
      status_hit = 1'b0;
      status_val = STATUS_MOVING;
      meas_hit   = 1'b0;
      meas_kind  = KIND_NONE;
      meas_val   = 8'd0;
      unique case (item.action) inside
         ACT_TEMP_SAMPLE: begin
            tsum_in = tsum_add[SUM_W] ? '1 : tsum_add[SUM_W-1:0];
         end
         ACT_LIGHT_SAMPLE: begin
            lsum_in = lsum_add[SUM_W] ? '1 : lsum_add[SUM_W-1:0];
         end
         ACT_TEMP_AVG, ACT_LIGHT_AVG: begin
            // close threshold wins over open threshold
            if (avg >= SUM_W'(thr_close)) begin
               if (mode_ff == MODE_UP) begin
                  mode_in    = MODE_LOWERING;
                  status_hit = 1'b1;
               end
            end else if (avg <= SUM_W'(thr_open)) begin
               if (mode_ff == MODE_DOWN) begin
                  mode_in    = MODE_RAISING;
                  status_hit = 1'b1;
               end
            end
            meas_hit = 1'b1;
            if (item.action == ACT_LIGHT_AVG) begin
               meas_kind = KIND_LIGHT;
               meas_val  = avg[7:0];
               lsum_in   = '0;
            end else begin
               meas_kind = KIND_TEMP;
               meas_val  = (temp_rep > (SUM_W+1)'(255)) ? 8'd255 : temp_rep[7:0];
               tsum_in   = '0;
            end
         end
         ACT_MOVE_TICK: begin
            if (mode_ff == MODE_LOWERING) begin
               pos_in = lower_pos;
               if (lower_pos >= 9'(closed_pos_ff)) begin
                  pos_in     = 9'(closed_pos_ff);
                  mode_in    = MODE_DOWN;
                  status_hit = 1'b1;
                  status_val = STATUS_CLOSED;
               end
            end else if (mode_ff == MODE_RAISING) begin
               pos_in = raise_pos;
               if (raise_pos <= 9'(open_pos_ff)) begin
                  pos_in     = 9'(open_pos_ff);
                  mode_in    = MODE_UP;
                  status_hit = 1'b1;
                  status_val = STATUS_OPEN;
               end
            end
         end
         ACT_OPEN: begin
            if (mode_ff == MODE_DOWN) begin
               mode_in    = MODE_RAISING;
               status_hit = 1'b1;
            end
         end
         ACT_CLOSE: begin
            if (mode_ff == MODE_UP) begin
               mode_in    = MODE_LOWERING;
               status_hit = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!item_go) begin
         mode_in = mode_ff;
         pos_in  = pos_ff;
         tsum_in = tsum_ff;
         lsum_in = lsum_ff;
      end
      // end-position writes snap the blind when it rests there
      if (csr_we && csr_index == CSR_OPEN_POS && mode_ff == MODE_UP) begin
         pos_in = 9'(csr_data);
      end
      if (csr_we && csr_index == CSR_CLOSED_POS && mode_ff == MODE_DOWN) begin
         pos_in = 9'(csr_data);
      end
   end

   // Result assembly: status first, then measurement
   always_comb begin
      res_a.blind_mode = mode_in;
      res_a.position   = pos_in;
      res_a.red_lamp   = (mode_in == MODE_LOWERING) || (mode_in == MODE_DOWN);
      res_a.green_lamp = (mode_in == MODE_UP) || (mode_in == MODE_RAISING);
      if (status_hit) begin
         res_a.report_kind  = KIND_STATUS;
         res_a.report_value = status_val;
      end else if (meas_hit) begin
         res_a.report_kind  = meas_kind;
         res_a.report_value = meas_val;
      end else begin
         res_a.report_kind  = KIND_NONE;
         res_a.report_value = 8'd0;
      end
      res_a.last         = !(status_hit && meas_hit);
      res_b              = res_a;
      res_b.report_kind  = meas_kind;
      res_b.report_value = meas_val;
      res_b.last         = 1'b1;
      push.valid  = item_go;
      push.two    = status_hit && meas_hit;
      push.first  = res_a;
      push.second = res_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         close_temp_ff  <= RST_CLOSE_TEMP;
         open_temp_ff   <= RST_OPEN_TEMP;
         close_light_ff <= RST_CLOSE_LIGHT;
         open_light_ff  <= RST_OPEN_LIGHT;
         open_pos_ff    <= RST_OPEN_POS;
         closed_pos_ff  <= RST_CLOSED_POS;
         move_step_ff   <= RST_MOVE_STEP;
         mode_ff        <= MODE_UP;
         pos_ff         <= 9'(RST_OPEN_POS);
         tsum_ff        <= '0;
         lsum_ff        <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         tsum_ff <= tsum_in;
         lsum_ff <= lsum_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_CLOSE_TEMP:  close_temp_ff  <= csr_data;
               CSR_OPEN_TEMP:   open_temp_ff   <= csr_data;
               CSR_CLOSE_LIGHT: close_light_ff <= csr_data;
               CSR_OPEN_LIGHT:  open_light_ff  <= csr_data;
               CSR_OPEN_POS:    open_pos_ff    <= csr_data;
               CSR_CLOSED_POS:  closed_pos_ff  <= csr_data;
               CSR_MOVE_STEP:   move_step_ff   <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   a_lamps_exclusive: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (push.first.red_lamp != push.first.green_lamp))
      else $error("lamp outputs not exclusive");

   a_pos_inside_limits: assert property (@(posedge clock) disable iff (reset)
      (item_go && item.action == ACT_MOVE_TICK && mode_ff == MODE_RAISING && mode_in == MODE_UP)
      |-> pos_in == 9'(open_pos_ff))
      else $error("raise did not settle at open position");

   a_two_needs_status: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.two) |-> (push.first.report_kind == KIND_STATUS
                                    && push.second.report_kind != KIND_STATUS))
      else $error("two-result beat out of order");

endmodule

### sv/sdbc_rsp_queue.sv
// Four-entry shift queue of result beats, filled one or two at a time.
module sdbc_rsp_queue
   import sdbc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  sdbc_push_type   push,
   output logic            room,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   rsp_payload_type    q_ff [QUEUE_DEPTH];
   rsp_payload_type    q_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0]  count_ff, count_in, base;
   logic               pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = q_ff[0];
   assign pop         = rsp_valid && !rsp_stall;
   // room for a two-beat push regardless of this cycle's pop
   assign room        = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   always_comb begin
      base = count_ff - QCNT_W'(pop);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         if (pop) begin
            q_in[i] = q_ff[i+1];
         end
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push.valid && QCNT_W'(i) == base) begin
            q_in[i] = push.first;
         end
         if (push.valid && push.two && QCNT_W'(i) == base + QCNT_W'(1)) begin
            q_in[i] = push.second;
         end
      end
      count_in = base + QCNT_W'(push.valid) + QCNT_W'(push.valid && push.two);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue count out of range");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> count_ff <= QCNT_W'(QUEUE_DEPTH - 2))
      else $error("push into full result queue");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push.valid) |=> count_ff == $past(count_ff) - QCNT_W'(1))
      else $error("pop did not drain one entry");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (push.first.last == !push.two))
      else $error("last flag inconsistent with beat count");

endmodule

### sv/sensor_driven_blind_controller_unit.sv
// Top level of the sensor-driven blind controller.
//
// Usage:
//   req_*  : one beat per event (action, 10-bit sample). Accepted when
//            req_valid is high and req_stall is low.
//   rsp_*  : result beats. Each event yields one beat, or two when an
//            average event also starts a movement (status first, then the
//            measurement); the final beat of an event has last set.
//   csr_*  : register writes, csr_ready is always high. Write only while
//            the block is idle. Index 7 is ignored.
// Flow: an accepted event is held in the input register until the queue
//   has room, is then evaluated and pushed into the result queue, and its
//   first beat shows on rsp_* once it reaches the registered queue head.
// Throughput: one event per cycle while each yields a single beat and
//   rsp_stall is low; the result port drains one beat per cycle while not
//   stalled, so two-beat events cannot keep up that event rate. The
//   4-entry result queue sets how far the two sides can drift apart.
// Reset: synchronous, clears state to blind up at position 10, empty sums,
//   default thresholds, empty queue.
// Stall: rsp_stall holds the head beat; once the queue cannot take two more
//   beats the input register holds its event and req_stall rises.
module sensor_driven_blind_controller_unit
   import sdbc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [2:0]      csr_index,
   input  logic [7:0]      csr_data
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff;
   logic            room;
   logic            item_go;
   logic            req_take;
   logic            csr_we;
   sdbc_push_type   push;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // input register advances into the core whenever the queue has room
   assign item_go   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (item_go) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_payload;
      end
   end

   sdbc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .item_go   (item_go),
      .item      (in_item_ff),
      .push      (push)
   );

   sdbc_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !room) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("input register lost a held event");

   a_go_needs_item: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> in_valid_ff)
      else $error("push without a held event");

   a_take_after_go: assert property (@(posedge clock) disable iff (reset)
      (item_go && !req_take) |=> !in_valid_ff)
      else $error("input register not emptied after advance");

endmodule
